// ----- sv/sbsn_pkg.sv -----
`default_nettype none
package sbsn_pkg;

  // sample store
  localparam int SAMPLE_DEPTH = 512;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

  // median filter window
  localparam int FILTER_WINDOW = 10;
  localparam int HALF_WIN      = FILTER_WINDOW / 2;
  localparam int WIN_LEN       = 2 * HALF_WIN;
  localparam int WIN_W         = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int HALF_W        = $clog2(HALF_WIN + 1);

  // Q3.13 angle constants
  localparam int PI_Q       = 25736;
  localparam int TWO_PI_Q   = 51472;
  localparam int OPPOSITE_Q = 25723;

  // navigation modes
  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_CIRC = 2'd1;
  localparam logic [1:0] MODE_GOAL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FORWARD_SPEED  = 3'd0;
  localparam logic [2:0] REG_CIRCLE_RATE    = 3'd1;
  localparam logic [2:0] REG_CIRCLE_SPEED   = 3'd2;
  localparam logic [2:0] REG_TURN_RATE      = 3'd3;
  localparam logic [2:0] REG_LEG_DISTANCE   = 3'd4;
  localparam logic [2:0] REG_ROTATE_MIN_MS  = 3'd5;
  localparam logic [2:0] REG_HEADING_MARGIN = 3'd6;

endpackage
`default_nettype wire

// ----- sv/sbsn_if.sv -----
`default_nettype none
// input request channel
interface sbsn_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] now_ms;
  logic signed [15:0] heading;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [7:0]  signal_strength;
  modport source (output valid, now_ms, heading, pos_x, pos_y, signal_strength,
                  input ready);
  modport sink   (input valid, now_ms, heading, pos_x, pos_y, signal_strength,
                  output ready);
endinterface

// result request channel
interface sbsn_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] vel_forward;
  logic               vel_side;
  logic signed [15:0] vel_yaw;
  logic        [1:0]  mode;
  modport source (output valid, vel_forward, vel_side, vel_yaw, mode, input ready);
  modport sink   (input valid, vel_forward, vel_side, vel_yaw, mode, output ready);
endinterface
`default_nettype wire

// ----- sv/signal_bearing_search_navigator_top.sv -----
`default_nettype none
// Sequence: a request passes through the eval, act and done steps to result valid; in forward
// mode a dist step first makes three passes of the shared 17x17 multiplier, and on
// the circle closure tick the median filter walks all N stored samples through the
// single store read port, with an address step and an insert step per window slot.
// Throughput: one request at a time; ready is high only between requests.
// Reset: synchronous, active high; registers take defaults, circle mode, no samples.
module signal_bearing_search_navigator_top (
  input  wire          clk,
  input  wire          rst,
  sbsn_in_if.sink      in_ch,
  sbsn_out_if.source   out_ch,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);

  localparam int AW = sbsn_pkg::ADDR_W;
  localparam int CW = sbsn_pkg::CNT_W;
  localparam int LN = sbsn_pkg::WIN_LEN;
  localparam int HW = sbsn_pkg::HALF_W;
  localparam int KW = sbsn_pkg::WIN_W;

  localparam logic signed [18:0] PI19  = 19'(sbsn_pkg::PI_Q);
  localparam logic signed [18:0] TPI19 = 19'(sbsn_pkg::TWO_PI_Q);
  localparam logic signed [18:0] OPP19 = 19'(sbsn_pkg::OPPOSITE_Q);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIST  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_FINIT = 4'd3;
  localparam logic [3:0] S_FADDR = 4'd4;
  localparam logic [3:0] S_FINS  = 4'd5;
  localparam logic [3:0] S_FHEAD = 4'd6;
  localparam logic [3:0] S_FGOAL = 4'd7;
  localparam logic [3:0] S_ACT   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  function automatic logic signed [18:0] wrap_pi(input logic signed [18:0] a);
    if (a > PI19) return a - TPI19;
    else if (a < -PI19) return a + TPI19;
    else return a;
  endfunction

  function automatic logic close_to(input logic signed [18:0] v,
                                    input logic signed [18:0] c,
                                    input logic [13:0] m);
    logic signed [18:0] ms;
    ms = {5'b0, m};
    return (v > c - ms) && (v < c + ms);
  endfunction

  // configuration registers
  logic        [14:0] forward_speed, circle_speed, turn_rate, leg_distance;
  logic signed [15:0] circle_rate;
  logic        [15:0] rotate_min_ms;
  logic        [13:0] heading_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed  <= 15'd4096;
      circle_rate    <= 16'sd8192;
      circle_speed   <= 15'd4096;
      turn_rate      <= 15'd4096;
      leg_distance   <= 15'd128;
      rotate_min_ms  <= 16'd1000;
      heading_margin <= 14'd819;
    end else if (cfg_we) begin
      case (cfg_index)
        sbsn_pkg::REG_FORWARD_SPEED:  forward_speed  <= cfg_data[14:0];
        sbsn_pkg::REG_CIRCLE_RATE:    circle_rate    <= cfg_data;
        sbsn_pkg::REG_CIRCLE_SPEED:   circle_speed   <= cfg_data[14:0];
        sbsn_pkg::REG_TURN_RATE:      turn_rate      <= cfg_data[14:0];
        sbsn_pkg::REG_LEG_DISTANCE:   leg_distance   <= cfg_data[14:0];
        sbsn_pkg::REG_ROTATE_MIN_MS:  rotate_min_ms  <= cfg_data;
        sbsn_pkg::REG_HEADING_MARGIN: heading_margin <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // navigation state
  logic [3:0]         state;
  logic [1:0]         nav_mode;
  logic               first_tick;
  logic [31:0]        mode_start_ms;
  logic signed [15:0] reference_heading;
  logic [CW-1:0]      sample_count;
  logic signed [15:0] goal_bearing;
  logic               turn_sign;
  logic signed [15:0] leg_start_x, leg_start_y;

  // latched request
  logic [31:0]        now_q;
  logic signed [15:0] hd_q, px_q, py_q;
  logic [7:0]         sig_q;

  // shared multiplier and distance
  logic [1:0]         mstep;
  logic signed [16:0] mul_a;
  logic signed [33:0] prod;
  logic [34:0]        dist_sq;
  logic [29:0]        leg_sq;

  // filter pass
  logic [AW-1:0]      sp, rp, fi, best;
  logic [HW-1:0]      dcnt;
  logic [KW-1:0]      k;
  logic [7:0]         win [LN];
  logic [7:0]         win_next [LN];
  logic [7:0]         minv;
  logic [7:0]         sig_rd;
  logic signed [15:0] hd_rd;

  // sample stores
  logic [7:0]         signal_store  [sbsn_pkg::SAMPLE_DEPTH];
  logic signed [15:0] heading_store [sbsn_pkg::SAMPLE_DEPTH];

  logic [AW-1:0]      n_last;
  logic [AW-1:0]      sp_inc, rp_inc;
  logic signed [18:0] rel_hd, goal_new, goal_diff;
  logic               closure, goal_hit;
  logic               in_acc;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign n_last      = AW'(sample_count - CW'(1));
  assign sp_inc      = (sp == n_last) ? '0 : sp + AW'(1);
  assign rp_inc      = (rp == n_last) ? '0 : rp + AW'(1);

  // multiplier operand select: dx, dy, then leg length
  always_comb begin
    case (mstep)
      2'd0:    mul_a = 17'(px_q) - 17'(leg_start_x);
      2'd1:    mul_a = 17'(py_q) - 17'(leg_start_y);
      default: mul_a = {2'b0, leg_distance};
    endcase
  end
  assign prod = mul_a * mul_a;

  // mode transition conditions
  assign rel_hd   = wrap_pi(19'(hd_q) - 19'(reference_heading));
  assign closure  = ((now_q - mode_start_ms) > {16'b0, rotate_min_ms}) &&
                    close_to(rel_hd, '0, heading_margin);
  assign goal_hit = close_to(rel_hd, 19'(goal_bearing), heading_margin);
  assign goal_new  = wrap_pi(19'(hd_rd) + OPP19);
  assign goal_diff = wrap_pi(19'(hd_q) - goal_new);

  // insertion of one sample into the sorted window
  always_comb begin
    logic gt_cur, gt_prev;
    for (int j = 0; j < LN; j++) begin
      gt_cur  = (j < 32'(k)) && (win[j] > sig_rd);
      gt_prev = (j > 0) && ((j - 1) < 32'(k)) && (win[(j > 0) ? j - 1 : 0] > sig_rd);
      if (gt_prev) win_next[j] = win[(j > 0) ? j - 1 : 0];
      else if (gt_cur || (j == 32'(k))) win_next[j] = sig_rd;
      else win_next[j] = win[j];
    end
  end

  // store ports
  always_ff @(posedge clk) begin
    if (state == S_ACT && nav_mode == sbsn_pkg::MODE_CIRC &&
        sample_count < CW'(sbsn_pkg::SAMPLE_DEPTH)) begin
      signal_store[sample_count[AW-1:0]]  <= sig_q;
      heading_store[sample_count[AW-1:0]] <= hd_q;
    end
    if (state == S_FADDR) sig_rd <= signal_store[rp];
    if (state == S_FHEAD) hd_rd <= heading_store[best];
  end

  // window registers
  always_ff @(posedge clk) begin
    if (state == S_FINS) begin
      for (int j = 0; j < LN; j++) win[j] <= win_next[j];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      nav_mode          <= sbsn_pkg::MODE_CIRC;
      first_tick        <= 1'b1;
      mode_start_ms     <= '0;
      reference_heading <= '0;
      sample_count      <= '0;
      goal_bearing      <= '0;
      turn_sign         <= 1'b0;
      leg_start_x       <= '0;
      leg_start_y       <= '0;
      out_ch.valid      <= 1'b0;
      mstep             <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            now_q <= in_ch.now_ms;
            hd_q  <= in_ch.heading;
            px_q  <= in_ch.pos_x;
            py_q  <= in_ch.pos_y;
            sig_q <= in_ch.signal_strength;
            mstep <= '0;
            if (first_tick) begin
              reference_heading <= in_ch.heading;
              mode_start_ms     <= in_ch.now_ms;
              first_tick        <= 1'b0;
            end
            state <= (nav_mode == sbsn_pkg::MODE_FWD) ? S_DIST : S_EVAL;
          end
        end
        S_DIST: begin
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: dist_sq <= 35'(prod);
            2'd1: dist_sq <= dist_sq + 35'(prod);
            default: begin
              leg_sq <= 30'(prod);
              state  <= S_EVAL;
            end
          endcase
        end
        S_EVAL: begin
          state <= S_ACT;
          case (nav_mode)
            sbsn_pkg::MODE_FWD: begin
              if (dist_sq > 35'(leg_sq)) begin
                reference_heading <= hd_q;
                sample_count      <= '0;
                nav_mode          <= sbsn_pkg::MODE_CIRC;
                mode_start_ms     <= now_q;
              end
            end
            sbsn_pkg::MODE_CIRC: begin
              if (closure) begin
                nav_mode          <= sbsn_pkg::MODE_GOAL;
                mode_start_ms     <= now_q;
                reference_heading <= hd_q;
                sp    <= '0;
                fi    <= '0;
                best  <= '0;
                dcnt  <= HW'(sbsn_pkg::HALF_WIN);
                state <= (sample_count == '0) ? S_FHEAD : S_FINIT;
              end
            end
            sbsn_pkg::MODE_GOAL: begin
              if (goal_hit) begin
                leg_start_x   <= px_q;
                leg_start_y   <= py_q;
                nav_mode      <= sbsn_pkg::MODE_FWD;
                mode_start_ms <= now_q;
              end
            end
            default: ;
          endcase
        end
        // window start for sample 0 sits HALF_WIN back, circularly
        S_FINIT: begin
          if (dcnt != '0) begin
            sp   <= (sp == '0) ? n_last : sp - AW'(1);
            dcnt <= dcnt - HW'(1);
          end else begin
            rp    <= sp;
            k     <= '0;
            state <= S_FADDR;
          end
        end
        S_FADDR: state <= S_FINS;
        S_FINS: begin
          rp <= rp_inc;
          if (k == KW'(LN - 1)) begin
            // median ready; keep first minimum
            if (fi == '0 || win_next[sbsn_pkg::HALF_WIN - 1] < minv) begin
              minv <= win_next[sbsn_pkg::HALF_WIN - 1];
              best <= fi;
            end
            if (fi == n_last) begin
              state <= S_FHEAD;
            end else begin
              fi    <= fi + AW'(1);
              sp    <= sp_inc;
              rp    <= sp_inc;
              k     <= '0;
              state <= S_FADDR;
            end
          end else begin
            k     <= k + KW'(1);
            state <= S_FADDR;
          end
        end
        S_FHEAD: state <= S_FGOAL;
        S_FGOAL: begin
          goal_bearing <= 16'(goal_new);
          turn_sign    <= goal_diff[18];
          state        <= S_ACT;
        end
        S_ACT: begin
          if (nav_mode == sbsn_pkg::MODE_CIRC &&
              sample_count < CW'(sbsn_pkg::SAMPLE_DEPTH))
            sample_count <= sample_count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.mode     <= nav_mode;
      out_ch.vel_side <= 1'b0;
      case (nav_mode)
        sbsn_pkg::MODE_FWD: begin
          out_ch.vel_forward <= forward_speed;
          out_ch.vel_yaw     <= '0;
        end
        sbsn_pkg::MODE_CIRC: begin
          out_ch.vel_forward <= circle_speed;
          out_ch.vel_yaw     <= circle_rate;
        end
        default: begin
          out_ch.vel_forward <= '0;
          out_ch.vel_yaw     <= turn_sign ? {1'b0, turn_rate} : -{1'b0, turn_rate};
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(sbsn_pkg::SAMPLE_DEPTH))
    else $error("sample count past store depth");
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    nav_mode != 2'd3) else $error("illegal navigation mode");
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready) else $error("ready while request in work");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == S_DONE))
    else $error("result raised outside done step");

endmodule
`default_nettype wire

// ----- test/signal_bearing_search_navigator_top_test.sv -----
`default_nettype none
module signal_bearing_search_navigator_top_test;

  typedef struct packed {
    logic        [31:0] now_ms;
    logic signed [15:0] heading;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [7:0]  signal_strength;
  } tick_t;

  typedef struct packed {
    logic        [14:0] vel_forward;
    logic               vel_side;
    logic signed [15:0] vel_yaw;
    logic        [1:0]  mode;
  } cmd_t;

  typedef struct packed {
    tick_t t;
    logic  typed;
    cmd_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = sbsn_pkg::REG_FORWARD_SPEED;
  logic [15:0] cfg_data = '0;

  sbsn_in_if  in_ch ();
  sbsn_out_if out_ch ();

  signal_bearing_search_navigator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // navigator copy: configuration
  int          fwd_speed, circ_speed, yaw_turn, leg_len, rot_min, margin;
  int          circ_rate;
  // navigator copy: state
  logic [1:0]  nav_mode;
  bit          first_tick;
  logic [31:0] mode_t0;
  int          ref_hd;
  byte unsigned sig_mem [sbsn_pkg::SAMPLE_DEPTH];
  int          hd_mem [sbsn_pkg::SAMPLE_DEPTH];
  int          n_samples;
  int          goal_hd;
  bit          turn_pos;
  int          leg_x, leg_y;

  cmd_t        cmd_queue [$];
  int          errors = 0;
  int          results_seen = 0;
  bit          no_idle = 1'b0;

  // stimulus shaping
  logic [31:0] clock_ms;
  int          spin;
  int          ms_step_max;

  function automatic int wrap_angle(int a);
    if (a > sbsn_pkg::PI_Q) return a - sbsn_pkg::TWO_PI_Q;
    if (a < -sbsn_pkg::PI_Q) return a + sbsn_pkg::TWO_PI_Q;
    return a;
  endfunction

  function automatic bit is_near(int v, int c);
    return v > c - margin && v < c + margin;
  endfunction

  // lower median over a circular window around sample i
  function automatic int median_at(int i, int n);
    int win [sbsn_pkg::WIN_LEN];
    int k, j, idx, v;
    for (k = 0; k < sbsn_pkg::WIN_LEN; k++) begin
      idx = ((i - sbsn_pkg::HALF_WIN + k) % n + n) % n;
      v = sig_mem[idx];
      for (j = k; j > 0 && win[j-1] > v; j--) win[j] = win[j-1];
      win[j] = v;
    end
    return win[sbsn_pkg::HALF_WIN-1];
  endfunction

  function automatic int bearing_from_samples();
    int best, minv, f, i;
    if (n_samples <= 0) return wrap_angle(sbsn_pkg::OPPOSITE_Q);
    best = 0;
    minv = median_at(0, n_samples);
    for (i = 1; i < n_samples; i++) begin
      f = median_at(i, n_samples);
      if (f < minv) begin
        minv = f;
        best = i;
      end
    end
    return wrap_angle(hd_mem[best] + sbsn_pkg::OPPOSITE_Q);
  endfunction

  function automatic void nav_reset();
    fwd_speed = 4096; circ_rate = 8192; circ_speed = 4096; yaw_turn = 4096;
    leg_len = 128; rot_min = 1000; margin = 819;
    nav_mode = sbsn_pkg::MODE_CIRC; first_tick = 1'b1; mode_t0 = '0; ref_hd = 0;
    n_samples = 0; goal_hd = 0; turn_pos = 1'b0; leg_x = 0; leg_y = 0;
  endfunction

  // one control tick of the navigator
  function automatic cmd_t nav_tick(tick_t t);
    cmd_t        c;
    int          hd, vf, vy;
    longint      dx, dy;
    logic [31:0] elapsed;
    hd = t.heading;
    vf = 0;
    vy = 0;
    if (first_tick) begin
      ref_hd = hd;
      mode_t0 = t.now_ms;
      first_tick = 1'b0;
    end
    elapsed = t.now_ms - mode_t0;
    if (nav_mode == sbsn_pkg::MODE_FWD) begin
      dx = longint'(t.pos_x) - leg_x;
      dy = longint'(t.pos_y) - leg_y;
      if (dx * dx + dy * dy > longint'(leg_len) * leg_len) begin
        ref_hd = hd;
        n_samples = 0;
        nav_mode = sbsn_pkg::MODE_CIRC;
        mode_t0 = t.now_ms;
      end
    end else if (nav_mode == sbsn_pkg::MODE_CIRC) begin
      if (elapsed > rot_min && is_near(wrap_angle(hd - ref_hd), 0)) begin
        goal_hd = bearing_from_samples();
        nav_mode = sbsn_pkg::MODE_GOAL;
        mode_t0 = t.now_ms;
        ref_hd = hd;
        turn_pos = wrap_angle(hd - goal_hd) < 0;
      end
    end else if (nav_mode == sbsn_pkg::MODE_GOAL) begin
      if (is_near(wrap_angle(hd - ref_hd), goal_hd)) begin
        leg_x = t.pos_x;
        leg_y = t.pos_y;
        nav_mode = sbsn_pkg::MODE_FWD;
        mode_t0 = t.now_ms;
      end
    end
    // action of the new mode
    if (nav_mode == sbsn_pkg::MODE_FWD) begin
      vf = fwd_speed;
    end else if (nav_mode == sbsn_pkg::MODE_CIRC) begin
      vf = circ_speed;
      vy = circ_rate;
      if (n_samples < sbsn_pkg::SAMPLE_DEPTH) begin
        sig_mem[n_samples] = t.signal_strength;
        hd_mem[n_samples] = hd;
        n_samples++;
      end
    end else if (nav_mode == sbsn_pkg::MODE_GOAL) begin
      vy = turn_pos ? yaw_turn : -yaw_turn;
    end
    c.vel_forward = vf[14:0];
    c.vel_side = 1'b0;
    c.vel_yaw = vy[15:0];
    c.mode = nav_mode;
    return c;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // random tick, steered by the current mode so that circles close and legs end
  function automatic tick_t next_tick();
    tick_t       t;
    int          r, off, d;
    logic [31:0] elapsed;
    r = $urandom_range(0, 99);
    clock_ms += (r < 2) ? $urandom : $urandom_range(1, ms_step_max);
    t.now_ms = clock_ms;
    t.signal_strength = $urandom;
    t.pos_x = $urandom;
    t.pos_y = $urandom;
    t.heading = $urandom_range(0, sbsn_pkg::TWO_PI_Q) - sbsn_pkg::PI_Q;
    elapsed = clock_ms - mode_t0;
    off = (margin > 1) ? $urandom_range(0, 2 * (margin - 1)) - (margin - 1) : 0;
    if (r >= 10) begin
      case (nav_mode)
        sbsn_pkg::MODE_CIRC: begin
          spin += $urandom_range(200, 3000);
          t.heading = wrap_angle(ref_hd + spin % sbsn_pkg::TWO_PI_Q);
          if (elapsed > rot_min && $urandom_range(0, 2) == 0)
            t.heading = wrap_angle(ref_hd + off);
        end
        sbsn_pkg::MODE_GOAL: begin
          if (r < 40) t.heading = wrap_angle(wrap_angle(ref_hd + goal_hd) + off);
        end
        default: begin
          if (r >= 30) begin
            d = $urandom_range(0, leg_len);
            t.pos_x = sat16(leg_x + ($urandom_range(0, 1) ? d : -d));
            d = $urandom_range(0, leg_len / 2);
            t.pos_y = sat16(leg_y + ($urandom_range(0, 1) ? d : -d));
          end
        end
      endcase
    end
    return t;
  endfunction

  // input side: one request, then a random gap
  task automatic send_tick(input tick_t t, input logic typed, input cmd_t want);
    cmd_t predicted;
    int   g;
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= t.now_ms;
    in_ch.heading <= t.heading;
    in_ch.pos_x <= t.pos_x;
    in_ch.pos_y <= t.pos_y;
    in_ch.signal_strength <= t.signal_strength;
    do @(posedge clk); while (!in_ch.ready);
    predicted = nav_tick(t);
    cmd_queue.push_back(typed ? want : predicted);
    g = idle_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    cmd_t none;
    none = '0;
    repeat (count) send_tick(next_tick(), 1'b0, none);
  endtask

  // stop offering and wait until every command is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      sbsn_pkg::REG_FORWARD_SPEED:  fwd_speed = value & 'h7FFF;
      sbsn_pkg::REG_CIRCLE_RATE:    circ_rate = 32'(signed'(value[15:0]));
      sbsn_pkg::REG_CIRCLE_SPEED:   circ_speed = value & 'h7FFF;
      sbsn_pkg::REG_TURN_RATE:      yaw_turn = value & 'h7FFF;
      sbsn_pkg::REG_LEG_DISTANCE:   leg_len = value & 'h7FFF;
      sbsn_pkg::REG_ROTATE_MIN_MS:  rot_min = value & 'hFFFF;
      sbsn_pkg::REG_HEADING_MARGIN: margin = value & 'h3FFF;
      default: ;
    endcase
  endtask

  task automatic write_all(input int fs, input int cr, input int cs, input int tr,
                           input int ld, input int rm, input int hm);
    write_reg(sbsn_pkg::REG_FORWARD_SPEED, fs);
    write_reg(sbsn_pkg::REG_CIRCLE_RATE, cr);
    write_reg(sbsn_pkg::REG_CIRCLE_SPEED, cs);
    write_reg(sbsn_pkg::REG_TURN_RATE, tr);
    write_reg(sbsn_pkg::REG_LEG_DISTANCE, ld);
    write_reg(sbsn_pkg::REG_ROTATE_MIN_MS, rm);
    write_reg(sbsn_pkg::REG_HEADING_MARGIN, hm);
  endtask

  task automatic write_random();
    write_all($urandom_range(0, 32767), $urandom_range(0, 65535) - 32768,
              $urandom_range(0, 32767), $urandom_range(0, 32767),
              $urandom_range(0, 4000), $urandom_range(0, 3000),
              $urandom_range(50, 8192));
  endtask

  // result side: check against the oldest expected command
  task automatic check_cmd();
    cmd_t e;
    if (cmd_queue.size() == 0) begin
      $display("%0t: unexpected command fwd=%0d yaw=%0d mode=%0d", $time,
               out_ch.vel_forward, out_ch.vel_yaw, out_ch.mode);
      errors++;
      return;
    end
    e = cmd_queue.pop_front();
    if (out_ch.vel_forward !== e.vel_forward) begin
      $display("%0t: vel_forward expected %0d got %0d", $time, e.vel_forward,
               out_ch.vel_forward);
      errors++;
    end
    if (out_ch.vel_side !== e.vel_side) begin
      $display("%0t: vel_side expected %0d got %0d", $time, e.vel_side, out_ch.vel_side);
      errors++;
    end
    if (out_ch.vel_yaw !== e.vel_yaw) begin
      $display("%0t: vel_yaw expected %0d got %0d", $time, e.vel_yaw, out_ch.vel_yaw);
      errors++;
    end
    if (out_ch.mode !== e.mode) begin
      $display("%0t: mode expected %0d got %0d", $time, e.mode, out_ch.mode);
      errors++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      check_cmd();
      results_seen++;
      if (results_seen == 1000) stall_left = 500;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = idle_len();
      out_ch.ready <= (stall_left == 0);
    end
  end

  // directed ticks under default registers
  localparam int N_ROWS = 12;
  row_t rows [N_ROWS];

  function automatic cmd_t mk(int vf, int vy, logic [1:0] m);
    cmd_t c;
    c.vel_forward = vf[14:0];
    c.vel_side = 1'b0;
    c.vel_yaw = vy[15:0];
    c.mode = m;
    return c;
  endfunction

  function automatic row_t mk_row(logic [31:0] now, int hd, int px, int py, int sig,
                                  logic typed, cmd_t want);
    row_t r;
    r.t.now_ms = now;
    r.t.heading = hd[15:0];
    r.t.pos_x = px[15:0];
    r.t.pos_y = py[15:0];
    r.t.signal_strength = sig[7:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    cmd_t circ_dflt;
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    in_ch.heading = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.signal_strength = '0;
    nav_reset();
    circ_dflt = mk(4096, 8192, sbsn_pkg::MODE_CIRC);
    // first tick, heading and signal extremes
    rows[0]  = mk_row(0, 0, 0, 0, 255, 1, circ_dflt);
    rows[1]  = mk_row(500, sbsn_pkg::PI_Q, 0, 0, 0, 1, circ_dflt);
    rows[2]  = mk_row(900, -sbsn_pkg::PI_Q, 0, 0, 128, 1, circ_dflt);
    // closure: flat filtered signal, first index wins, turn positive
    rows[3]  = mk_row(1001, 0, 0, 0, 7, 1, mk(0, 4096, sbsn_pkg::MODE_GOAL));
    rows[4]  = mk_row(1100, sbsn_pkg::OPPOSITE_Q, -32768, -32768, 0, 1,
                      mk(4096, 0, sbsn_pkg::MODE_FWD));
    rows[5]  = mk_row(1200, 100, -32704, -32768, 1, 1, mk(4096, 0, sbsn_pkg::MODE_FWD));
    // leg end from the far corner, time about to wrap
    rows[6]  = mk_row(32'hFFFF_FF00, -100, 32767, 32767, 200, 1, circ_dflt);
    rows[7]  = mk_row(32'h0000_00F0, 12000, 32767, 32767, 17, 1, circ_dflt);
    // heading exactly on the margin is not close
    rows[8]  = mk_row(32'h0000_02F0, 719, 32767, 32767, 85, 1, circ_dflt);
    rows[9]  = mk_row(32'h0000_0300, 400, 5, -5, 90, 0, '0);
    rows[10] = mk_row(32'h0000_0400, -sbsn_pkg::PI_Q, 1234, -4321, 255, 0, '0);
    rows[11] = mk_row(32'h0000_0500, sbsn_pkg::PI_Q, -1, 1, 170, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_tick(rows[i].t, rows[i].typed, rows[i].want);
    clock_ms = 32'h0000_0500;
    spin = 0;
    ms_step_max = 150;

    // default registers
    send_random(350);
    drain();

    // extremes one way, back to back
    no_idle = 1'b1;
    write_all(32767, -32768, 0, 32767, 0, 0, 8192);
    send_random(250);
    drain();
    no_idle = 1'b0;

    // extremes the other way
    write_all(0, 32767, 32767, 0, 32767, 200, 1);
    send_random(200);
    drain();

    // fill the sample store past its depth, long receiver hold-off falls here
    write_all(4096, 8192, 4096, 4096, 128, 1000, 819);
    while (nav_mode != sbsn_pkg::MODE_CIRC) send_random(1);
    drain();
    write_reg(sbsn_pkg::REG_HEADING_MARGIN, 0);
    write_reg(sbsn_pkg::REG_ROTATE_MIN_MS, 65535);
    ms_step_max = 140;
    send_random(540);
    drain();
    ms_step_max = 150;

    // random settings
    write_random();
    write_reg(sbsn_pkg::REG_HEADING_MARGIN, 8192);
    send_random(100);
    drain();
    write_random();
    send_random(100);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ----- signal_bearing_search_navigator_top.f -----
sv/sbsn_pkg.sv
sv/sbsn_if.sv
sv/signal_bearing_search_navigator_top.sv
test/signal_bearing_search_navigator_top_test.sv
